// ===== sv/soe_pkg.sv =====
// ----------------------------------------------------------------------------
// Scaler overflow extension package
// Store geometry, compare mask, stream widths and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package soe_pkg;

   localparam int MODULES  = 8;
   localparam int CHANNELS = 32;
   localparam int ENTRIES  = MODULES * CHANNELS;
   localparam int ENTRY_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int MOD_W  = 3;
   localparam int CHN_W  = 5;
   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] CMP_MASK = 32'hffffffc0;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 80;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef struct packed {
      logic load;
      logic clear;
      logic commit;
   } soe_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic in_range;
   } soe_sts_type;

endpackage

`default_nettype wire

// ===== sv/soe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scaler overflow extension controller
// Sequences accept, store read, update/commit and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module soe_ctrl
   import soe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire soe_sts_type sts,
   output      soe_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_CALC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (sts.is_clear) begin
                  cmd.clear = 1'b1;
               end else if (sts.in_range) begin
                  cmd.load = 1'b1;
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_commit_in_calc: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> state_ff == S_CALC)
      else $error("commit outside update state");

   a_load_to_calc: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_CALC)
      else $error("load did not enter update state");

   a_rsp_from_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_CALC)
      else $error("result raised without update");

   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear && (cmd.load || cmd.commit)))
      else $error("clear overlaps sample work");

endmodule

`default_nettype wire

// ===== sv/soe_datapath.sv =====
// ----------------------------------------------------------------------------
// Scaler overflow extension datapath
// Entry store with valid bits, masked compare, wrap increment, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module soe_datapath
   import soe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // module_req, channel, reading,
                                                  // overflow_seen, report, zero pad
   input  wire logic                  req_tuser,  // action
   input  wire soe_cmd_type           cmd,
   output      soe_sts_type           sts,
   output      logic [RSP_DATA_W-1:0] rsp_tdata   // out_module, out_channel, high_word,
                                                  // low_word, clear_overflow,
                                                  // backward_jump, reported, zero pad
);

   logic [MOD_W-1:0]  in_mod;
   logic [CHN_W-1:0]  in_chn;
   logic [WORD_W-1:0] in_reading;
   logic [ENTRY_W-1:0] in_entry;

   logic [2*WORD_W-1:0] mem_ff [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;

   logic [2*WORD_W-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic [ENTRY_W-1:0]  entry_ff;
   logic [MOD_W-1:0]    mod_ff;
   logic [CHN_W-1:0]    chn_ff;
   logic [WORD_W-1:0]   reading_ff;
   logic                ovf_ff;
   logic                report_ff;

   logic [WORD_W-1:0] old_high;
   logic [WORD_W-1:0] old_low;
   logic              fell;
   logic              wrap;
   logic [WORD_W-1:0] high_in;

   logic [RSP_DATA_W-1:0] rsp_ff;
   logic [RSP_DATA_W-1:0] rsp_in;

   assign in_mod     = req_tdata[2:0];
   assign in_chn     = req_tdata[7:3];
   assign in_reading = req_tdata[39:8];
   assign in_entry   = ENTRY_W'(32'(in_mod) * CHANNELS + 32'(in_chn));

   assign sts.is_clear = (req_tuser == ACT_CLEAR);
   assign sts.in_range = (32'(in_mod) < MODULES) && (32'(in_chn) < CHANNELS);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_data_ff  <= mem_ff[in_entry];
         rd_valid_ff <= valid_ff[in_entry];
         entry_ff    <= in_entry;
         mod_ff      <= in_mod;
         chn_ff      <= in_chn;
         reading_ff  <= in_reading;
         ovf_ff      <= req_tdata[40];
         report_ff   <= req_tdata[41];
      end
      if (cmd.commit) begin
         mem_ff[entry_ff] <= {high_in, reading_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[entry_ff] <= 1'b1;
      end
   end

   assign old_high = rd_valid_ff ? rd_data_ff[2*WORD_W-1:WORD_W] : '0;
   assign old_low  = rd_valid_ff ? rd_data_ff[WORD_W-1:0] : '0;
   assign fell     = (reading_ff & CMP_MASK) < (old_low & CMP_MASK);
   assign wrap     = fell && ovf_ff;
   assign high_in  = old_high + WORD_W'(wrap);

   assign rsp_in = {5'b0, report_ff, fell && !ovf_ff, wrap,
                    reading_ff, high_in, chn_ff, mod_ff};

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/scaler_overflow_extension.sv =====
// ----------------------------------------------------------------------------
// Scaler overflow extension
// Extends 32-bit scaler readings to 64 bits per module and channel.
// ----------------------------------------------------------------------------
// Flow: the entry is read at the accepting edge; the update and the result
// register load in the update state, which holds while the
// previous result is still waiting for its transfer.
// A new sample is taken only after the previous one is committed, as the store
// reads then writes one entry; clear gives no result.
// Reset: synchronous; all entries read as zero, no result pending.
`default_nettype none

module scaler_overflow_extension
   import soe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // module_req, channel, reading,
                                                  // overflow_seen, report, zero pad
   input  wire logic                  req_tuser,  // action
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata   // out_module, out_channel, high_word,
                                                  // low_word, clear_overflow,
                                                  // backward_jump, reported, zero pad
);

   soe_cmd_type cmd;
   soe_sts_type sts;

   soe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   soe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Scaler overflow extension testbench
// Drives samples and clears through the request stream with random gaps and
// result-side stalls, and checks each result against a scoreboard that keeps
// its own copy of the per-channel wrap counts and stored readings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import soe_pkg::*;

   typedef struct packed {
      logic [REQ_DATA_W-43:0] pad;
      logic                   report;
      logic                   overflow_seen;
      logic [WORD_W-1:0]      reading;
      logic [CHN_W-1:0]       channel;
      logic [MOD_W-1:0]       module_req;
   } sample_req_type;

   typedef struct packed {
      logic [RSP_DATA_W-76:0] pad;
      logic                   reported;
      logic                   backward_jump;
      logic                   clear_overflow;
      logic [WORD_W-1:0]      low_word;
      logic [WORD_W-1:0]      high_word;
      logic [CHN_W-1:0]       out_channel;
      logic [MOD_W-1:0]       out_module;
   } count_rsp_type;

   class wrap_scoreboard;
      logic [WORD_W-1:0] wrap_count [ENTRIES];
      logic [WORD_W-1:0] last_reading [ENTRIES];
      count_rsp_type     count_q [$];
      int                errors;

      function new();
         errors = 0;
         clear_store();
      endfunction

      function void clear_store();
         foreach (wrap_count[i]) begin
            wrap_count[i]   = '0;
            last_reading[i] = '0;
         end
      endfunction

      // predict the result of one accepted transfer
      function void note_transfer(logic action, sample_req_type req);
         count_rsp_type rsp;
         int            idx;
         rsp = '0;
         if (action == ACT_CLEAR) begin
            clear_store();
         end else if (req.module_req < MODULES && req.channel < CHANNELS) begin
            idx = req.module_req * CHANNELS + req.channel;
            if ((req.reading & CMP_MASK) < (last_reading[idx] & CMP_MASK)) begin
               if (req.overflow_seen) begin
                  wrap_count[idx]    = wrap_count[idx] + WORD_W'(1);
                  rsp.clear_overflow = 1'b1;
               end else begin
                  rsp.backward_jump = 1'b1;
               end
            end
            last_reading[idx] = req.reading;
            rsp.out_module    = req.module_req;
            rsp.out_channel   = req.channel;
            rsp.high_word     = wrap_count[idx];
            rsp.low_word      = req.reading;
            rsp.reported      = req.report;
            count_q.push_back(rsp);
         end
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] exp_val,
                                  logic [WORD_W-1:0] act_val);
         if (exp_val !== act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
         end
      endfunction

      function void check_result(count_rsp_type act);
         count_rsp_type exp_rsp;
         if (count_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, act);
         end else begin
            exp_rsp = count_q.pop_front();
            compare_field("out_module", WORD_W'(exp_rsp.out_module),
                          WORD_W'(act.out_module));
            compare_field("out_channel", WORD_W'(exp_rsp.out_channel),
                          WORD_W'(act.out_channel));
            compare_field("high_word", exp_rsp.high_word, act.high_word);
            compare_field("low_word", exp_rsp.low_word, act.low_word);
            compare_field("clear_overflow", WORD_W'(exp_rsp.clear_overflow),
                          WORD_W'(act.clear_overflow));
            compare_field("backward_jump", WORD_W'(exp_rsp.backward_jump),
                          WORD_W'(act.backward_jump));
            compare_field("reported", WORD_W'(exp_rsp.reported),
                          WORD_W'(act.reported));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // module_req, channel, reading,
                                       // overflow_seen, report, zero pad
   logic                  req_tuser;   // action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // out_module, out_channel, high_word,
                                       // low_word, clear_overflow,
                                       // backward_jump, reported, zero pad

   wrap_scoreboard sb;
   int             accepted;
   bit             calm;
   bit             held_long;

   scaler_overflow_extension dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(count_rsp_type'(rsp_tdata));
      end
   end

   // result side: random stalls, one long hold-off, none near the end
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_long && accepted >= 400) begin
            held_long = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_item(logic action, logic [MOD_W-1:0] mod_idx,
                            logic [CHN_W-1:0] chn_idx, logic [WORD_W-1:0] value,
                            logic ovf, logic rep);
      sample_req_type req;
      req               = '0;
      req.module_req    = mod_idx;
      req.channel       = chn_idx;
      req.reading       = value;
      req.overflow_seen = ovf;
      req.report        = rep;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= req;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      sb.note_transfer(action, req);
      accepted++;
   endtask

   task automatic send_random_sample(int hot_idx [4]);
      int                idx;
      logic [WORD_W-1:0] prev;
      logic [WORD_W-1:0] value;
      int                pick;
      if ($urandom_range(0, 9) < 7) begin
         idx = hot_idx[$urandom_range(0, 3)];
      end else begin
         idx = $urandom_range(0, ENTRIES - 1);
      end
      prev = sb.last_reading[idx];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         value = prev + $urandom_range(0, 1000);
      end else if (pick < 65) begin
         value = prev - $urandom_range(0, 200);
      end else begin
         value = $urandom;
      end
      send_item(ACT_SAMPLE, MOD_W'(idx / CHANNELS), CHN_W'(idx % CHANNELS), value,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int hot_idx [4];
      int waited;
      sb         = new();
      accepted   = 0;
      calm       = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_SAMPLE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: compare edges, wraps, backward jumps, clears
      send_item(ACT_SAMPLE, 3'd0, 5'd0, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'hffff_ffff, 1'b1, 1'b1);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'hffff_ffc0, 1'b0, 1'b0);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'h0000_003f, 1'b0, 1'b1);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'h0000_0040, 1'b0, 1'b0);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'h0000_0000, 1'b1, 1'b1);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'hffff_ffff, 1'b1, 1'b0);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'h0000_0012, 1'b1, 1'b1);
      send_item(ACT_SAMPLE, 3'd3, 5'd17, 32'haaaa_aaaa, 1'b0, 1'b1);
      send_item(ACT_SAMPLE, 3'd3, 5'd17, 32'h5555_5555, 1'b1, 1'b0);
      send_item(ACT_SAMPLE, 3'd3, 5'd17, 32'h5555_5555, 1'b1, 1'b1);
      send_item(ACT_CLEAR, 3'd5, 5'd9, 32'hdead_beef, 1'b1, 1'b1);
      send_item(ACT_SAMPLE, 3'd7, 5'd31, 32'h0000_0000, 1'b1, 1'b1);
      send_item(ACT_SAMPLE, 3'd3, 5'd17, 32'h5555_5555, 1'b0, 1'b0);
      send_item(ACT_CLEAR, 3'd0, 5'd0, 32'h0000_0000, 1'b0, 1'b0);
      send_item(ACT_SAMPLE, 3'd0, 5'd0, 32'h8000_0000, 1'b0, 1'b1);
      send_item(ACT_SAMPLE, 3'd0, 5'd0, 32'h7fff_ffff, 1'b0, 1'b0);
      send_item(ACT_SAMPLE, 3'd4, 5'd16, 32'h0000_0001, 1'b1, 1'b0);

      // random: mostly a few busy channels, rare clears, quiet tail
      foreach (hot_idx[i]) hot_idx[i] = $urandom_range(0, ENTRIES - 1);
      for (int i = 0; i < 1230; i++) begin
         if (i >= 1080) calm = 1'b1;
         if ($urandom_range(0, 99) == 0) begin
            send_item(ACT_CLEAR, MOD_W'($urandom), CHN_W'($urandom), $urandom,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            send_random_sample(hot_idx);
         end
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (sb.count_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.count_q.size() != 0) begin
         $display("FAIL");
         $finish;
      end else begin
         repeat (10) @(posedge clock);
         if (sb.errors == 0 && sb.count_q.size() == 0) begin
            $display("PASS");
         end else begin
            $display("FAIL");
         end
         $finish;
      end
   end

endmodule

// ===== scaler_overflow_extension.f =====
sv/soe_pkg.sv
sv/soe_ctrl.sv
sv/soe_datapath.sv
sv/scaler_overflow_extension.sv
dv/tb.sv
